### rtl/csc_pkg.sv
// Package for the sparse matrix symmetry checker: sizes, word types, state
// enums and the IEEE double equality function. No dependencies.
`default_nettype none
package csc_pkg;

    localparam int MAX_DIM     = 1024;
    localparam int MAX_ENTRIES = 8192;

    localparam int ROW_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = ROW_W + 1;
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int EADDR_W  = $clog2(MAX_ENTRIES);
    localparam int VAL_W    = 64;
    localparam int ENTRY_W  = ROW_W + VAL_W;
    localparam int ROWREC_W = 2 * CNT_W;

    typedef enum logic [1:0] {
        V_SYM      = 2'd0,
        V_MISSING  = 2'd1,
        V_MISMATCH = 2'd2,
        V_ERROR    = 2'd3
    } t_verdict;

    typedef struct packed {
        logic [ROW_W-1:0] entry_row;
        logic [ROW_W-1:0] entry_col;
        logic [VAL_W-1:0] entry_value;
        logic             last_entry;
    } t_entry;

    typedef struct packed {
        t_verdict         verdict;
        logic [ROW_W-1:0] bad_row;
        logic [ROW_W-1:0] bad_col;
        logic [VAL_W-1:0] lower_value;
        logic [VAL_W-1:0] upper_value;
    } t_result;

    // Start request from the loader to the checker.
    typedef struct packed {
        logic start;
        logic err;
    } t_chk_req;

    typedef enum logic [1:0] {
        L_CLEAR,
        L_LOAD,
        L_FLUSH,
        L_WAIT
    } t_load_state;

    typedef enum logic [3:0] {
        C_IDLE,
        C_ROW_RD,
        C_ROW_WAIT,
        C_J_TEST,
        C_J_WAIT,
        C_M_WAIT,
        C_K_TEST,
        C_K_WAIT,
        C_OUT
    } t_chk_state;

    function automatic logic is_nan(input logic [VAL_W-1:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    // IEEE equality: both zeros match regardless of sign, NaN matches nothing.
    function automatic logic ieee_equal(input logic [VAL_W-1:0] a,
                                        input logic [VAL_W-1:0] b);
        logic res;
        if (is_nan(a) || is_nan(b)) begin
            res = 1'b0;
        end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
            res = 1'b1;
        end else begin
            res = (a == b);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/csc_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module csc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/csc_loader.sv
// Load side of the symmetry checker: size register, row table clearing pass,
// entry validation and writes to the entry and row memories. Uses csc_pkg.
`default_nettype none
module csc_loader (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [csc_pkg::DIM_W-1:0]       i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire csc_pkg::t_entry                 i_entry,
    output logic                                 o_ent_we,
    output logic [csc_pkg::EADDR_W-1:0]          o_ent_waddr,
    output logic [csc_pkg::ENTRY_W-1:0]          o_ent_wdata,
    output logic                                 o_row_we,
    output logic [csc_pkg::ROW_W-1:0]            o_row_waddr,
    output logic [csc_pkg::ROWREC_W-1:0]         o_row_wdata,
    output csc_pkg::t_chk_req                    o_req,
    input  wire logic                            i_done
);
    import csc_pkg::*;

    t_load_state        r_state, n_state;
    logic [DIM_W-1:0]   r_size;
    logic [ROW_W-1:0]   r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_err, n_err;
    logic               r_have_prev, n_have_prev;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [ROW_W-1:0]   r_prev_col, n_prev_col;
    logic [CNT_W-1:0]   r_cur_start, n_cur_start;
    logic [CNT_W-1:0]   r_cur_cnt, n_cur_cnt;

    logic [DIM_W-1:0]   size_eff;
    logic               accept;
    logic               bad_idx;
    logic               ovf;
    logic               bad_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= L_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_have_prev <= 1'b0;
            r_cur_row   <= '0;
            r_prev_col  <= '0;
            r_cur_start <= '0;
            r_cur_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_count     <= n_count;
            r_err       <= n_err;
            r_have_prev <= n_have_prev;
            r_cur_row   <= n_cur_row;
            r_prev_col  <= n_prev_col;
            r_cur_start <= n_cur_start;
            r_cur_cnt   <= n_cur_cnt;
        end
    end

    assign size_eff = (r_size > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_size;
    assign o_ready  = (r_state == L_LOAD);
    assign accept   = i_valid && o_ready;
    assign bad_idx  = ({1'b0, i_entry.entry_row} >= size_eff) ||
                      ({1'b0, i_entry.entry_col} >= size_eff);
    assign ovf      = (r_count >= CNT_W'(MAX_ENTRIES));
    assign bad_order = r_have_prev &&
                       ((i_entry.entry_row < r_cur_row) ||
                        ((i_entry.entry_row == r_cur_row) &&
                         (i_entry.entry_col < r_prev_col)));

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_err       = r_err;
        n_have_prev = r_have_prev;
        n_cur_row   = r_cur_row;
        n_prev_col  = r_prev_col;
        n_cur_start = r_cur_start;
        n_cur_cnt   = r_cur_cnt;
        o_ent_we    = 1'b0;
        o_ent_waddr = r_count[EADDR_W-1:0];
        o_ent_wdata = {i_entry.entry_col, i_entry.entry_value};
        o_row_we    = 1'b0;
        o_row_waddr = r_cur_row;
        o_row_wdata = {r_cur_start, r_cur_cnt};
        o_req       = '0;

        case (r_state)
            L_CLEAR: begin
                o_row_we    = 1'b1;
                o_row_waddr = r_clr_addr;
                o_row_wdata = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == ROW_W'(MAX_DIM - 1)) begin
                    n_state = L_LOAD;
                end
            end
            L_LOAD: begin
                if (accept) begin
                    if (!r_err) begin
                        if (bad_idx || ovf || bad_order) begin
                            n_err = 1'b1;
                        end else begin
                            o_ent_we = 1'b1;
                            // A new row closes the previous one in the row table.
                            if (!r_have_prev || (i_entry.entry_row != r_cur_row)) begin
                                o_row_we    = r_have_prev;
                                n_cur_row   = i_entry.entry_row;
                                n_cur_start = r_count;
                                n_cur_cnt   = CNT_W'(1);
                            end else begin
                                n_cur_cnt = r_cur_cnt + 1'b1;
                            end
                            n_count     = r_count + 1'b1;
                            n_have_prev = 1'b1;
                            n_prev_col  = i_entry.entry_col;
                        end
                    end
                    if (i_entry.last_entry) begin
                        n_state = L_FLUSH;
                    end
                end
            end
            L_FLUSH: begin
                o_row_we  = r_have_prev;
                o_req.start = 1'b1;
                o_req.err   = r_err;
                n_state   = L_WAIT;
            end
            L_WAIT: begin
                if (i_done) begin
                    n_state     = L_CLEAR;
                    n_clr_addr  = '0;
                    n_count     = '0;
                    n_err       = 1'b0;
                    n_have_prev = 1'b0;
                    n_cur_row   = '0;
                    n_prev_col  = '0;
                end
            end
            default: begin
                n_state = L_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/csc_checker.sv
// Check side of the symmetry checker: walks the row table and entry memory,
// searches each lower entry's mirror and holds the verdict. Uses csc_pkg.
`default_nettype none
module csc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire csc_pkg::t_chk_req               i_req,
    output logic                                 o_done,
    output logic                                 o_row_re,
    output logic [csc_pkg::ROW_W-1:0]            o_row_raddr,
    input  wire logic [csc_pkg::ROWREC_W-1:0]    i_row_rdata,
    output logic                                 o_ent_re,
    output logic [csc_pkg::EADDR_W-1:0]          o_ent_raddr,
    input  wire logic [csc_pkg::ENTRY_W-1:0]     i_ent_rdata,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output csc_pkg::t_result                     o_result
);
    import csc_pkg::*;

    t_chk_state        r_state, n_state;
    logic [DIM_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_jend, n_jend;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_kend, n_kend;
    logic [ROW_W-1:0]  r_c, n_c;
    logic [VAL_W-1:0]  r_lv, n_lv;
    t_result           r_result, n_result;

    logic [CNT_W-1:0]  rd_start;
    logic [CNT_W-1:0]  rd_cnt;
    logic [ROW_W-1:0]  rd_col;
    logic [VAL_W-1:0]  rd_val;
    logic              last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_jend   <= n_jend;
        r_k      <= n_k;
        r_kend   <= n_kend;
        r_c      <= n_c;
        r_lv     <= n_lv;
        r_result <= n_result;
    end

    assign rd_start = i_row_rdata[ROWREC_W-1 -: CNT_W];
    assign rd_cnt   = i_row_rdata[CNT_W-1:0];
    assign rd_col   = i_ent_rdata[ENTRY_W-1 -: ROW_W];
    assign rd_val   = i_ent_rdata[VAL_W-1:0];
    assign last_row = (r_i == DIM_W'(MAX_DIM - 1));
    assign o_valid  = (r_state == C_OUT);
    assign o_result = r_result;

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_jend      = r_jend;
        n_k         = r_k;
        n_kend      = r_kend;
        n_c         = r_c;
        n_lv        = r_lv;
        n_result    = r_result;
        o_done      = 1'b0;
        o_row_re    = 1'b0;
        o_row_raddr = r_i[ROW_W-1:0];
        o_ent_re    = 1'b0;
        o_ent_raddr = r_j[EADDR_W-1:0];

        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    if (i_req.err) begin
                        n_result         = '0;
                        n_result.verdict = V_ERROR;
                        n_state          = C_OUT;
                    end else begin
                        n_i     = '0;
                        n_state = C_ROW_RD;
                    end
                end
            end
            C_ROW_RD: begin
                o_row_re = 1'b1;
                n_state  = C_ROW_WAIT;
            end
            C_ROW_WAIT: begin
                n_j     = rd_start;
                n_jend  = rd_start + rd_cnt;
                n_state = C_J_TEST;
            end
            C_J_TEST: begin
                if (r_j == r_jend) begin
                    n_i = r_i + 1'b1;
                    if (last_row) begin
                        n_result         = '0;
                        n_result.verdict = V_SYM;
                        n_state          = C_OUT;
                    end else begin
                        n_state = C_ROW_RD;
                    end
                end else begin
                    o_ent_re = 1'b1;
                    n_state  = C_J_WAIT;
                end
            end
            C_J_WAIT: begin
                if ({1'b0, rd_col} >= r_i) begin
                    // Diagonal or upper part reached: the rest of the row is skipped.
                    n_i = r_i + 1'b1;
                    if (last_row) begin
                        n_result         = '0;
                        n_result.verdict = V_SYM;
                        n_state          = C_OUT;
                    end else begin
                        n_state = C_ROW_RD;
                    end
                end else begin
                    n_c         = rd_col;
                    n_lv        = rd_val;
                    o_row_re    = 1'b1;
                    o_row_raddr = rd_col;
                    n_state     = C_M_WAIT;
                end
            end
            C_M_WAIT: begin
                n_k     = rd_start;
                n_kend  = rd_start + rd_cnt;
                n_state = C_K_TEST;
            end
            C_K_TEST: begin
                if (r_k == r_kend) begin
                    n_result.verdict     = V_MISSING;
                    n_result.bad_row     = r_i[ROW_W-1:0];
                    n_result.bad_col     = r_c;
                    n_result.lower_value = r_lv;
                    n_result.upper_value = '0;
                    n_state              = C_OUT;
                end else begin
                    o_ent_re    = 1'b1;
                    o_ent_raddr = r_k[EADDR_W-1:0];
                    n_state     = C_K_WAIT;
                end
            end
            C_K_WAIT: begin
                if ({1'b0, rd_col} == r_i) begin
                    if (!ieee_equal(rd_val, r_lv)) begin
                        n_result.verdict     = V_MISMATCH;
                        n_result.bad_row     = r_i[ROW_W-1:0];
                        n_result.bad_col     = r_c;
                        n_result.lower_value = r_lv;
                        n_result.upper_value = rd_val;
                        n_state              = C_OUT;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = C_J_TEST;
                    end
                end else if ({1'b0, rd_col} > r_i) begin
                    n_result.verdict     = V_MISSING;
                    n_result.bad_row     = r_i[ROW_W-1:0];
                    n_result.bad_col     = r_c;
                    n_result.lower_value = r_lv;
                    n_result.upper_value = '0;
                    n_state              = C_OUT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = C_K_TEST;
                end
            end
            C_OUT: begin
                if (i_ready) begin
                    o_done  = 1'b1;
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/csr_symmetry_checker.sv
// Top level of the sparse matrix symmetry checker: loader, checker and the
// row table and entry memories. Uses csc_pkg, csc_ram, csc_loader, csc_checker.
//
// Usage:
// Entry words arrive on the input channel (i_valid / o_ready) as row, column,
// value and a last flag, sorted by row and then by column. During loading one
// word is accepted per cycle. The word with the last flag closes the matrix.
// After the last word the loader's flush state sends the start request and the
// checker then walks the row table. Each row, each lower entry and each probed
// mirror entry waits on a registered memory read. The full walk covers all
// MAX_DIM rows. An error seen during loading (index out of range, order
// violation or overflow) gives verdict 3, sent to the output channel without
// a walk.
// The verdict word stays on the output channel (o_valid / i_ready) until
// the receiver takes it; while it waits no input word is accepted.
// After reset, and after every delivered verdict, the row table is cleared
// one row a cycle through all MAX_DIM rows, with o_ready low. The matrix
// size register can be written at any idle time and keeps its value.
`default_nettype none
module csr_symmetry_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [csc_pkg::DIM_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire csc_pkg::t_entry           i_entry,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output csc_pkg::t_result               o_result
);
    import csc_pkg::*;

    logic                 ent_we;
    logic [EADDR_W-1:0]   ent_waddr;
    logic [ENTRY_W-1:0]   ent_wdata;
    logic                 ent_re;
    logic [EADDR_W-1:0]   ent_raddr;
    logic [ENTRY_W-1:0]   ent_rdata;
    logic                 row_we;
    logic [ROW_W-1:0]     row_waddr;
    logic [ROWREC_W-1:0]  row_wdata;
    logic                 row_re;
    logic [ROW_W-1:0]     row_raddr;
    logic [ROWREC_W-1:0]  row_rdata;
    t_chk_req             req;
    logic                 done;

    // Loading side: validates each word, stores column and value in arrival
    // order and writes one {start, count} record per row once the row closes.
    csc_loader u_loader (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_entry     (i_entry),
        .o_ent_we    (ent_we),
        .o_ent_waddr (ent_waddr),
        .o_ent_wdata (ent_wdata),
        .o_row_we    (row_we),
        .o_row_waddr (row_waddr),
        .o_row_wdata (row_wdata),
        .o_req       (req),
        .i_done      (done)
    );

    // Row table: start offset and entry count for each row.
    csc_ram #(
        .WIDTH (ROWREC_W),
        .DEPTH (MAX_DIM)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Entry memory: column index and value bits of every stored entry.
    csc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // Checking side: walks rows, looks up each lower entry's mirror and holds
    // the verdict until it is taken.
    csc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_done      (done),
        .o_row_re    (row_re),
        .o_row_raddr (row_raddr),
        .i_row_rdata (row_rdata),
        .o_ent_re    (ent_re),
        .o_ent_raddr (ent_raddr),
        .i_ent_rdata (ent_rdata),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

### tb/sv/csc_symmetry_monitor.sv
// Monitor and predictor for the sparse matrix symmetry checker: watches the
// entry and verdict channels, predicts each verdict and compares. Uses csc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csc_symmetry_monitor (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [csc_pkg::DIM_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    input  wire logic                      i_ready_in,
    input  wire csc_pkg::t_entry           i_entry,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire csc_pkg::t_result          i_result,
    output int                             o_fail_count,
    output int                             o_pending
);
    import csc_pkg::*;

    logic [DIM_W-1:0] size_reg;
    int unsigned      row_count [MAX_DIM+1];
    logic [ROW_W-1:0] col_mem [MAX_ENTRIES];
    logic [VAL_W-1:0] val_mem [MAX_ENTRIES];
    int unsigned      stored;
    bit               load_err;
    bit               have_prev;
    logic [ROW_W-1:0] prev_row, prev_col;
    t_result          verdict_q [$];

    function automatic bit dbl_equal(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        bit an, bn;
        an = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
        bn = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
        if (an || bn) return 0;
        if (a[62:0] == 0 && b[62:0] == 0) return 1;
        return a == b;
    endfunction

    function automatic void clear_matrix();
        foreach (row_count[i]) row_count[i] = 0;
        stored = 0;
        load_err = 0;
        have_prev = 0;
        prev_row = '0;
        prev_col = '0;
    endfunction

    // Prefix-sum the row counts and walk every lower entry looking for its mirror.
    function automatic t_result symmetry_verdict();
        t_result     r;
        int unsigned offs [MAX_DIM+1];
        int unsigned c, k;
        bit          found;
        r = '0;
        r.verdict = V_SYM;
        offs[0] = row_count[0];
        for (int i = 1; i <= MAX_DIM; i++) offs[i] = offs[i-1] + row_count[i];
        for (int i = 0; i < MAX_DIM; i++) begin
            for (int unsigned j = offs[i]; j < offs[i+1]; j++) begin
                c = col_mem[j];
                found = 0;
                if (c >= i) break;
                for (k = offs[c]; k < offs[c+1]; k++) begin
                    if (col_mem[k] == i) begin
                        if (!dbl_equal(val_mem[k], val_mem[j])) begin
                            r.verdict = V_MISMATCH;
                            r.bad_row = i;
                            r.bad_col = c;
                            r.lower_value = val_mem[j];
                            r.upper_value = val_mem[k];
                            return r;
                        end
                        found = 1;
                        break;
                    end
                    if (col_mem[k] > i) break;
                end
                if (!found) begin
                    r.verdict = V_MISSING;
                    r.bad_row = i;
                    r.bad_col = c;
                    r.lower_value = val_mem[j];
                    return r;
                end
            end
        end
        return r;
    endfunction

    function automatic void take_entry(t_entry e);
        int unsigned sz;
        sz = (size_reg > MAX_DIM) ? MAX_DIM : size_reg;
        if (!load_err) begin
            if (e.entry_row >= sz || e.entry_col >= sz) begin
                load_err = 1;
            end else if (stored >= MAX_ENTRIES) begin
                load_err = 1;
            end else if (have_prev && (e.entry_row < prev_row ||
                         (e.entry_row == prev_row && e.entry_col < prev_col))) begin
                load_err = 1;
            end else begin
                col_mem[stored] = e.entry_col;
                val_mem[stored] = e.entry_value;
                stored++;
                row_count[e.entry_row + 1]++;
                have_prev = 1;
                prev_row = e.entry_row;
                prev_col = e.entry_col;
            end
        end
        if (e.last_entry) begin
            t_result r;
            r = '0;
            if (load_err) r.verdict = V_ERROR;
            else r = symmetry_verdict();
            verdict_q.push_back(r);
            clear_matrix();
        end
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            size_reg <= 11'd1024;
            clear_matrix();
            verdict_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) size_reg <= i_cfg_data;
            if (i_valid && i_ready_in) take_entry(i_entry);
            if (i_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected verdict word %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (want !== i_result) begin
                        if (o_fail_count < 10)
                            $display("verdict mismatch: expected %p got %p", want, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench top for csr_symmetry_checker: drives matrices of entry words and
// the size register, and gives the verdict. Uses csc_pkg and csc_symmetry_monitor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import csc_pkg::*;

    // A whole-table walk and the clearing pass run with no handshake at all, so
    // the watchdog limit is set well above both.
    localparam int WATCHDOG = 400000;

    logic             clk = 0;
    logic             rst_n = 0;
    logic             cfg_we = 0;
    logic [DIM_W-1:0] cfg_data = '0;
    logic             in_valid = 0;
    logic             in_ready;
    t_entry           entry = '0;
    logic             out_valid;
    logic             out_ready = 0;
    t_result          result;
    int               fails;
    int               pending;
    int               quiet_cycles = 0;
    bit               no_gaps = 0;
    int unsigned      cur_size = 1024;
    int               words_sent = 0;

    always #1 clk = ~clk;

    csr_symmetry_checker u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready), .i_entry(entry),
        .o_valid(out_valid), .i_ready(out_ready), .o_result(result)
    );

    csc_symmetry_monitor u_mon (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_entry(entry),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_result(result),
        .o_fail_count(fails), .o_pending(pending)
    );

    // The receiver stalls about one cycle in ten, except in the gap-free stretch.
    always @(posedge clk) begin
        out_ready <= no_gaps || ($urandom_range(99) >= 10);
    end

    // The watchdog ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sends one entry word and waits for it to be taken. Valid is left high
    // afterwards: the next word replaces it at the same edge, or a random gap
    // drops it first, so valid only changes once per edge.
    task automatic send_word(input int unsigned r, input int unsigned c,
                             input logic [63:0] v, input bit last);
        while (!no_gaps && $urandom_range(99) < 10) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        entry.entry_row <= r[ROW_W-1:0];
        entry.entry_col <= c[ROW_W-1:0];
        entry.entry_value <= v;
        entry.last_entry <= last;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Stops sending and waits until every predicted verdict has been taken.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // The size register is only written with input stopped and all verdicts in.
    task automatic write_size(input int unsigned s);
        drain();
        repeat (8) @(posedge clk);
        cfg_we <= 1;
        cfg_data <= s[DIM_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        cur_size = (s > MAX_DIM) ? MAX_DIM : s;
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return 64'h0;
            1: return 64'h8000_0000_0000_0000;
            2: return 64'h7FF8_0000_0000_0001;
            3: return 64'h7FF0_0000_0000_0000;
            4: return {2'($urandom_range(3)), 62'h0} | 64'($urandom_range(15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Sends a random symmetric-ish matrix of n positions plus mirrors, sorted, with
    // occasional corruption: a missing or changed mirror, a bad index or bad order.
    task automatic send_matrix(input int n);
        logic [63:0] vals [int];
        int unsigned rows [$], cols [$];
        logic [63:0] v [$];
        int unsigned r, c, tmp;
        int          key;
        int          noise;
        noise = $urandom_range(99);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(cur_size - 1);
            c = $urandom_range(cur_size - 1);
            if (c > r) begin tmp = r; r = c; c = tmp; end
            key = r * 1024 + c;
            if (!vals.exists(key)) vals[key] = pick_value();
        end
        foreach (vals[k]) begin
            r = k / 1024; c = k % 1024;
            if (!vals.exists(c * 1024 + r)) vals[c * 1024 + r] = vals[k];
        end
        if (noise < 15 && vals.size() > 1) begin
            void'(vals.first(key));
            vals[key] = pick_value();
        end
        foreach (vals[k]) begin
            rows.push_back(k / 1024);
            cols.push_back(k % 1024);
            v.push_back(vals[k]);
        end
        if (noise >= 15 && noise < 22 && rows.size() > 2) rows.delete(1);
        if (noise >= 22 && noise < 26 && rows.size() > 2) begin
            tmp = rows[0]; rows[0] = rows[1]; rows[1] = tmp;
            tmp = cols[0]; cols[0] = cols[1]; cols[1] = tmp;
        end
        if (noise >= 26 && noise < 29) rows[0] = $urandom_range(1023, cur_size);
        for (int i = 0; i < rows.size(); i++)
            send_word(rows[i], cols[i], v[i], i == rows.size() - 1);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // Directed part at full size.
        send_word(0, 0, 64'h0, 1);
        send_word(1023, 1023, 64'hFFFF_FFFF_FFFF_FFFF, 1);
        send_word(0, 1023, 64'h1, 0);
        send_word(1023, 0, 64'h1, 1);
        send_word(3, 1, 64'h0, 0);
        send_word(1, 3, 64'h8000_0000_0000_0000, 1);
        send_word(1, 3, 64'h7FF8_0000_0000_0000, 0);
        send_word(3, 1, 64'h7FF8_0000_0000_0000, 1);
        send_word(2, 0, 64'h5, 1);
        send_word(0, 2, 64'h5, 0);
        send_word(2, 0, 64'h6, 1);
        send_word(2, 2, 64'h1, 0);
        send_word(2, 1, 64'h1, 1);
        send_word(5, 5, 64'h1, 0);
        send_word(5, 5, 64'h2, 1);
        send_word(1, 2, 64'h9, 0);
        send_word(1, 2, 64'h8, 0);
        send_word(2, 1, 64'h9, 1);
        drain();
        write_size(0);
        send_word(0, 0, 64'h1, 1);
        write_size(2047);
        send_word(1023, 1022, 64'h1, 0);
        send_word(1023, 1023, 64'h1, 1);
        write_size(1);
        send_word(0, 0, 64'hAAAA_5555_AAAA_5555, 0);
        send_word(0, 1, 64'h1, 1);

        // Random part: mostly small sizes, a few large ones.
        while (words_sent < 1350) begin
            if ($urandom_range(9) == 0)
                write_size(($urandom_range(5) == 0) ? 1024 : $urandom_range(16, 1));
            if (words_sent > 500 && words_sent < 700) no_gaps = 1;
            else no_gaps = 0;
            if (words_sent > 900 && words_sent < 960) drain();
            send_matrix($urandom_range(12, 1));
        end

        drain();
        repeat (4000) @(posedge clk);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### csr_symmetry_checker.f
rtl/csc_pkg.sv
rtl/csc_ram.sv
rtl/csc_loader.sv
rtl/csc_checker.sv
rtl/csr_symmetry_checker.sv
tb/sv/csc_symmetry_monitor.sv
tb/sv/tb.sv
